// File: rtl/nfba_pkg.sv
// Shared constants, codes and controller/datapath handshake types for the block allocator.
package nfba_pkg;

    localparam int KIND_W    = 2;
    localparam int OBJ_W     = 16;
    localparam int CNT_W     = 4;
    localparam int PIECE_W   = 3;
    localparam int TAG_W     = 4;
    localparam int AREA_W    = 12;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 12;

    localparam int DISK_BLOCKS    = 4096;
    localparam int MAX_OBJ_BLOCKS = 8;
    localparam int BLK_W          = $clog2(DISK_BLOCKS);
    localparam int BND_W          = BLK_W + 1;

    localparam logic [BND_W-1:0]  DISK_END   = BND_W'(DISK_BLOCKS);
    localparam logic [BLK_W-1:0]  LAST_BLOCK = BLK_W'(DISK_BLOCKS - 1);
    localparam logic [AREA_W-1:0] RW_RESET   = AREA_W'(2048);
    localparam logic [CNT_W-1:0]  CNT_MAX    = CNT_W'(MAX_OBJ_BLOCKS);

    typedef enum logic [KIND_W-1:0] {
        KIND_WHOLE  = 2'd0,
        KIND_RW     = 2'd1,
        KIND_BACKUP = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    localparam logic [CFG_IDX_W-1:0] CFG_RW_AREA  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISK_NUM = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_step;
        logic load;
        logic rd;
        logic place;
        logic skip;
        logic full;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic req_ok;
        logic exhausted;
        logic blk_free;
        logic out_free;
        logic last_piece;
    } t_sts;

endpackage

// File: rtl/nfba_if.sv
// Channel interfaces of the block allocator: request, result and configuration write.
interface nfba_req_if;
    logic                         valid;
    logic                         ready;
    logic [nfba_pkg::KIND_W-1:0]  kind;
    logic [nfba_pkg::OBJ_W-1:0]   obj_id;
    logic [nfba_pkg::CNT_W-1:0]   obj_blocks;

    modport source (output valid, kind, obj_id, obj_blocks, input ready);
    modport sink   (input valid, kind, obj_id, obj_blocks, output ready);
endinterface

interface nfba_res_if;
    logic                          valid;
    logic                          ready;
    logic [nfba_pkg::BLK_W-1:0]    block_index;
    logic [nfba_pkg::PIECE_W-1:0]  piece;
    logic [nfba_pkg::OBJ_W-1:0]    obj_owner;
    logic [nfba_pkg::TAG_W-1:0]    disk_tag;
    logic                          last;
    logic                          full_res;

    modport source (output valid, block_index, piece, obj_owner, disk_tag, last, full_res,
                    input ready);
    modport sink   (input valid, block_index, piece, obj_owner, disk_tag, last, full_res,
                    output ready);
endinterface

interface nfba_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [nfba_pkg::CFG_IDX_W-1:0] index;
    logic [nfba_pkg::CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/nfba_datapath.sv
// Datapath: configuration, region cursors, occupancy memory, scan registers and result register.
module nfba_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  nfba_pkg::t_cmd                 i_cmd,
    output nfba_pkg::t_sts                 o_sts,
    input  logic [nfba_pkg::KIND_W-1:0]    i_kind,
    input  logic [nfba_pkg::OBJ_W-1:0]     i_obj_id,
    input  logic [nfba_pkg::CNT_W-1:0]     i_obj_blocks,
    input  logic                           i_cfg_we,
    input  logic [nfba_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [nfba_pkg::CFG_DAT_W-1:0] i_cfg_data,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic [nfba_pkg::BLK_W-1:0]     o_block_index,
    output logic [nfba_pkg::PIECE_W-1:0]   o_piece,
    output logic [nfba_pkg::OBJ_W-1:0]     o_obj_owner,
    output logic [nfba_pkg::TAG_W-1:0]     o_disk_tag,
    output logic                           o_last,
    output logic                           o_full_res
);

    localparam int BLK_W = nfba_pkg::BLK_W;
    localparam int BND_W = nfba_pkg::BND_W;

    logic [nfba_pkg::AREA_W-1:0] r_rw_area;
    logic [nfba_pkg::TAG_W-1:0]  r_disk_num;
    logic [BND_W-1:0]            r_cur_whole, r_cur_rw, r_cur_bak;
    nfba_pkg::t_kind             r_kind;
    logic [BND_W-1:0]            r_lo, r_hi, r_cur, r_tries;
    logic [nfba_pkg::CNT_W-1:0]  r_piece, r_count;
    logic [nfba_pkg::OBJ_W-1:0]  r_owner;
    logic [BLK_W-1:0]            r_clr_addr;
    logic                        r_occ [nfba_pkg::DISK_BLOCKS];
    logic                        r_occ_q;
    logic                        r_out_valid;
    logic [BLK_W-1:0]            r_out_blk;
    logic [nfba_pkg::PIECE_W-1:0] r_out_piece;
    logic [nfba_pkg::OBJ_W-1:0]  r_out_owner;
    logic [nfba_pkg::TAG_W-1:0]  r_out_tag;
    logic                        r_out_last, r_out_full;

    logic [BND_W-1:0]            w_rw_ext, w_split, w_lo, w_hi, w_sel, w_start;
    logic [BND_W-1:0]            w_inc, w_next;
    logic [nfba_pkg::CNT_W-1:0]  w_cnt, w_piece_inc;
    nfba_pkg::t_kind             w_kind;
    logic                        w_out_free, w_mem_we;
    logic [BLK_W-1:0]            w_mem_addr;

    // Region bounds from the current split point.
    assign w_rw_ext = BND_W'(r_rw_area);
    assign w_split  = (w_rw_ext > nfba_pkg::DISK_END) ? nfba_pkg::DISK_END : w_rw_ext;
    assign w_kind   = nfba_pkg::t_kind'(i_kind);

    always_comb begin
        case (w_kind)
            nfba_pkg::KIND_WHOLE: begin
                w_lo  = '0;
                w_hi  = nfba_pkg::DISK_END;
                w_sel = r_cur_whole;
            end
            nfba_pkg::KIND_RW: begin
                w_lo  = '0;
                w_hi  = w_split;
                w_sel = r_cur_rw;
            end
            default: begin
                w_lo  = w_split;
                w_hi  = nfba_pkg::DISK_END;
                w_sel = r_cur_bak;
            end
        endcase
    end

    assign w_start = (w_sel < w_lo || w_sel >= w_hi) ? w_lo : w_sel;
    assign w_cnt   = (i_obj_blocks > nfba_pkg::CNT_MAX) ? nfba_pkg::CNT_MAX : i_obj_blocks;

    assign w_inc       = r_cur + BND_W'(1);
    assign w_next      = (w_inc >= r_hi) ? r_lo : w_inc;
    assign w_piece_inc = r_piece + nfba_pkg::CNT_W'(1);
    assign w_out_free  = !r_out_valid || i_out_ready;

    assign o_sts.clr_last   = (r_clr_addr == nfba_pkg::LAST_BLOCK);
    assign o_sts.req_ok     = (w_kind != nfba_pkg::KIND_NONE) && (i_obj_blocks != '0);
    assign o_sts.exhausted  = (r_tries >= (r_hi - r_lo));
    assign o_sts.blk_free   = !r_occ_q;
    assign o_sts.out_free   = w_out_free;
    assign o_sts.last_piece = (w_piece_inc == r_count);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rw_area  <= nfba_pkg::RW_RESET;
            r_disk_num <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                nfba_pkg::CFG_RW_AREA:  r_rw_area  <= i_cfg_data[nfba_pkg::AREA_W-1:0];
                nfba_pkg::CFG_DISK_NUM: r_disk_num <= i_cfg_data[nfba_pkg::TAG_W-1:0];
                default: ;
            endcase
        end
    end

    // Region cursors. The start point is written back at load: the saved cursor if it lies
    // inside its region, else the region's low bound.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_whole <= '0;
            r_cur_rw    <= '0;
            r_cur_bak   <= BND_W'(nfba_pkg::RW_RESET);
        end else if (i_cmd.load) begin
            case (w_kind)
                nfba_pkg::KIND_WHOLE: r_cur_whole <= w_start;
                nfba_pkg::KIND_RW:    r_cur_rw    <= w_start;
                default:              r_cur_bak   <= w_start;
            endcase
        end else if (i_cmd.place) begin
            case (r_kind)
                nfba_pkg::KIND_WHOLE: r_cur_whole <= w_next;
                nfba_pkg::KIND_RW:    r_cur_rw    <= w_next;
                default:              r_cur_bak   <= w_next;
            endcase
        end
    end

    // Scan registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_addr <= r_clr_addr + BLK_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= w_kind;
            r_lo    <= w_lo;
            r_hi    <= w_hi;
            r_cur   <= w_start;
            r_tries <= '0;
            r_piece <= '0;
            r_count <= w_cnt;
            r_owner <= i_obj_id;
        end else if (i_cmd.place) begin
            r_cur   <= w_next;
            r_tries <= '0;
            r_piece <= w_piece_inc;
        end else if (i_cmd.skip) begin
            r_cur   <= w_next;
            r_tries <= r_tries + BND_W'(1);
        end
    end

    // Occupancy memory: one access per cycle, registered read data.
    assign w_mem_we   = i_cmd.clr_step || i_cmd.place;
    assign w_mem_addr = i_cmd.clr_step ? r_clr_addr : r_cur[BLK_W-1:0];

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_occ[w_mem_addr] <= i_cmd.place;
        end
        if (i_cmd.rd) begin
            r_occ_q <= r_occ[w_mem_addr];
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.place || i_cmd.full) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.place || i_cmd.full) begin
            r_out_blk   <= i_cmd.full ? '0 : r_cur[BLK_W-1:0];
            r_out_piece <= r_piece[nfba_pkg::PIECE_W-1:0];
            r_out_owner <= r_owner;
            r_out_tag   <= r_disk_num;
            r_out_last  <= i_cmd.full || o_sts.last_piece;
            r_out_full  <= i_cmd.full;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_block_index = r_out_blk;
    assign o_piece       = r_out_piece;
    assign o_obj_owner   = r_out_owner;
    assign o_disk_tag    = r_out_tag;
    assign o_last        = r_out_last;
    assign o_full_res    = r_out_full;

endmodule

// File: rtl/nfba_ctrl.sv
// Controller: clearing pass, request acceptance and the probe/check scan sequence.
module nfba_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  nfba_pkg::t_sts i_sts,
    output nfba_pkg::t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_CLR,
        S_IDLE,
        S_RD,
        S_CHK
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid && i_sts.req_ok) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RD;
                end
            end
            S_RD: begin
                if (i_sts.exhausted) begin
                    if (i_sts.out_free) begin
                        o_cmd.full = 1'b1;
                        n_state    = S_IDLE;
                    end
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_CHK;
                end
            end
            S_CHK: begin
                if (!i_sts.blk_free) begin
                    o_cmd.skip = 1'b1;
                    n_state    = S_RD;
                end else if (i_sts.out_free) begin
                    o_cmd.place = 1'b1;
                    n_state     = i_sts.last_piece ? S_IDLE : S_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: rtl/next_fit_block_allocator.sv
// Top level of the next-fit block allocator: channel wiring of controller and datapath.
//
// Channel  Dir  Modport  Payload
// i_req    in   sink     kind, obj_id, obj_blocks
// o_res    out  source   block_index, piece, obj_owner, disk_tag, last, full_res
// i_cfg    in   sink     index (0 rw_area_size, 1 disk_number), data
//
// A request transaction is accepted in the idle state; each block examined then passes through
// a read state (one occupancy memory read) and a check state, and a full region gives its result
// only after every block in the region has been tried and the result register is free.
// After reset a clearing pass writes all 4096 occupancy entries, one a cycle, before any
// request is taken; configuration writes are taken at any time outside reset. A stalled
// result holds the scan's next output, but the next request is taken while the last result still waits.
module next_fit_block_allocator (
    input logic         i_clk,
    input logic         i_rst_n,
    nfba_req_if.sink    i_req,
    nfba_res_if.source  o_res,
    nfba_cfg_if.sink    i_cfg
);

    nfba_pkg::t_cmd w_cmd;
    nfba_pkg::t_sts w_sts;

    // Ready outside reset. The user must write registers only while idle; the block does not enforce it.
    assign i_cfg.ready = i_rst_n;

    // The controller sequences the clearing pass and the scan; it sees only status and the request valid.
    nfba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // The datapath holds all storage but the controller state, including the result register that decouples
    // the scan from the downstream consumer.
    nfba_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_kind        (i_req.kind),
        .i_obj_id      (i_req.obj_id),
        .i_obj_blocks  (i_req.obj_blocks),
        .i_cfg_we      (i_cfg.valid),
        .i_cfg_index   (i_cfg.index),
        .i_cfg_data    (i_cfg.data),
        .i_out_ready   (o_res.ready),
        .o_out_valid   (o_res.valid),
        .o_block_index (o_res.block_index),
        .o_piece       (o_res.piece),
        .o_obj_owner   (o_res.obj_owner),
        .o_disk_tag    (o_res.disk_tag),
        .o_last        (o_res.last),
        .o_full_res    (o_res.full_res)
    );

endmodule

// File: rtl/nfba_checker.sv
// Port-level checker for the block allocator and its bind to the top level.
module nfba_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_req_ready,
    input logic                        i_res_valid,
    input logic                        i_res_ready,
    input logic [nfba_pkg::BLK_W-1:0]  i_res_block_index,
    input logic [nfba_pkg::PIECE_W-1:0] i_res_piece,
    input logic                        i_res_last,
    input logic                        i_res_full
);

    // A result that is not taken stays offered with the same payload.
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=>
            i_res_valid && $stable(i_res_block_index) && $stable(i_res_piece)
            && $stable(i_res_last) && $stable(i_res_full))
        else $error("result changed while stalled");

    // A full region ends the request.
    a_full_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_full |-> i_res_last)
        else $error("full result without last");

    // A full result carries no block.
    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_full |-> i_res_block_index == '0)
        else $error("full result with nonzero block index");

    // No request is taken right after reset while the occupancy memory is cleared.
    a_clear_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !i_req_ready)
        else $error("request taken during clearing pass");

endmodule

bind next_fit_block_allocator nfba_checker u_nfba_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_req_ready       (i_req.ready),
    .i_res_valid       (o_res.valid),
    .i_res_ready       (o_res.ready),
    .i_res_block_index (o_res.block_index),
    .i_res_piece       (o_res.piece),
    .i_res_last        (o_res.last),
    .i_res_full        (o_res.full_res)
);
